@@ sv/isma_pkg.sv @@
// Shared types and constants for the interval-sampled moving average core.
// Used by the front, queue, back and top modules and the checkers; has no dependencies of its own.
package isma_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int DATA_W      = 16;
    localparam int INTERVAL_W  = 16;
    localparam int WINDOW_W    = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5000;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 7'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              stored;
    } tick_t;

    typedef struct packed {
        logic                  clear;
        logic [INTERVAL_W-1:0] interval;
        logic [WINDOW_W-1:0]   window;
    } cfg_ctl_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

@@ sv/isma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/isma_fifo.sv @@
// Short request queue between the front and back parts.
// Depends on isma_pkg.
module isma_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  isma_pkg::tick_t push_data,
    output logic           full,
    input  logic           pop,
    output isma_pkg::tick_t head,
    output logic           empty
);

    isma_pkg::tick_t                  slot_reg [isma_pkg::QUEUE_DEPTH];
    logic [isma_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [isma_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [isma_pkg::QPTR_W:0]        count_reg, count_next;

    assign full  = (count_reg == (isma_pkg::QPTR_W+1)'(isma_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/isma_front.sv @@
// Front part: accepts ticks, runs the elapsed-tick counter and marks sampling ticks.
// Depends on isma_pkg; feeds isma_fifo.
module isma_front #(
    parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  isma_pkg::cfg_ctl_t            cfg,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [isma_pkg::DATA_W-1:0]   s_axis_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output isma_pkg::tick_t               q_data
);

    localparam int SW = (SAMPLE_BITS < isma_pkg::DATA_W) ? SAMPLE_BITS : isma_pkg::DATA_W;
    localparam logic [isma_pkg::DATA_W-1:0] SMASK = {isma_pkg::DATA_W{1'b1}} >> (isma_pkg::DATA_W - SW);

    logic [isma_pkg::INTERVAL_W-1:0] elapsed_reg, elapsed_next;
    logic [isma_pkg::INTERVAL_W-1:0] tick_count;
    logic [isma_pkg::INTERVAL_W-1:0] interval_eff;
    logic                            store;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        interval_eff  = (cfg.interval == '0) ? isma_pkg::INTERVAL_W'(1) : cfg.interval;
        tick_count    = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        store         = (tick_count >= interval_eff);
        q_data.sample = s_axis_tdata & SMASK;
        q_data.stored = store;
        elapsed_next  = elapsed_reg;
        if (q_push)
        begin
            elapsed_next = store ? '0 : tick_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

@@ sv/isma_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module isma_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW:0]   r_shift;
    logic [DW:0]   r_sub;
    logic          ge;

    assign done     = done_reg;
    assign quotient = q_reg;

    always_comb
    begin
        r_shift   = {r_reg, q_reg[NW-1]};
        r_sub     = r_shift - {1'b0, d_reg};
        ge        = (r_shift >= {1'b0, d_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[NW-2:0], ge};
            r_next   = ge ? r_sub[DW-1:0] : r_shift[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ sv/isma_back.sv @@
// Back part: updates the sample ring and running sum, divides, and holds the result.
// Depends on isma_pkg, isma_ram and isma_div.
module isma_back #(
    parameter int WINDOW_MAX  = isma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  isma_pkg::cfg_ctl_t          cfg,
    input  logic                        q_empty,
    input  isma_pkg::tick_t             q_head,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [isma_pkg::DATA_W-1:0] m_axis_tdata,
    output logic [0:0]                  m_axis_tuser
);

    localparam int SW   = (SAMPLE_BITS < isma_pkg::DATA_W) ? SAMPLE_BITS : isma_pkg::DATA_W;
    localparam int WW   = $clog2(WINDOW_MAX + 1);
    localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUMW = SW + WW;

    isma_pkg::back_state_t state_reg, state_next;

    isma_pkg::tick_t              item_reg, item_next;
    logic [IW-1:0]                widx_reg, widx_next;
    logic                         wrapped_reg, wrapped_next;
    logic [SUMW-1:0]              sum_reg, sum_next;
    logic [isma_pkg::DATA_W-1:0]  held_reg, held_next;
    logic                         mvalid_reg, mvalid_next;
    logic [isma_pkg::DATA_W-1:0]  mdata_reg, mdata_next;
    logic                         muser_reg, muser_next;

    logic [WW-1:0]   win_eff;
    logic [IW-1:0]   idx;
    logic [WW-1:0]   idx_inc;
    logic            wrap;
    logic [SW-1:0]   old_val;
    logic [SW-1:0]   rd_data;
    logic [SUMW-1:0] sum_new;
    logic            rd_en;
    logic            wr_en;
    logic            div_start;
    logic            div_done;
    logic [SUMW-1:0] quotient;
    logic            out_free;
    logic            out_load;

    assign m_axis_tvalid   = mvalid_reg;
    assign m_axis_tdata    = mdata_reg;
    assign m_axis_tuser[0] = muser_reg;
    assign out_free        = !mvalid_reg || m_axis_tready;

    always_comb
    begin
        if (cfg.window == '0)
        begin
            win_eff = WW'(1);
        end
        else if (int'(cfg.window) > WINDOW_MAX)
        begin
            win_eff = WW'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WW'(cfg.window);
        end
        idx     = (WW'(widx_reg) >= win_eff) ? '0 : widx_reg;
        idx_inc = WW'(idx) + 1'b1;
        wrap    = (idx_inc >= win_eff);
        old_val = wrapped_reg ? rd_data : '0;
        sum_new = sum_reg - SUMW'(old_val) + SUMW'(item_reg.sample[SW-1:0]);
    end

    isma_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx),
        .wr_data (item_reg.sample[SW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    isma_div #(
        .NW (SUMW),
        .DW (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (win_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isma_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_head.stored ? isma_pkg::B_READ : isma_pkg::B_OUT;
                end
            end
            isma_pkg::B_READ:
            begin
                state_next = isma_pkg::B_DIV;
            end
            isma_pkg::B_DIV:
            begin
                if (div_done)
                begin
                    state_next = isma_pkg::B_OUT;
                end
            end
            isma_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = isma_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = isma_pkg::B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            isma_pkg::B_IDLE:
            begin
                q_pop = !q_empty;
                rd_en = !q_empty && q_head.stored;
            end
            isma_pkg::B_READ:
            begin
                wr_en     = 1'b1;
                div_start = 1'b1;
            end
            isma_pkg::B_DIV:
            begin
            end
            isma_pkg::B_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        item_next    = q_pop ? q_head : item_reg;
        widx_next    = widx_reg;
        wrapped_next = wrapped_reg;
        sum_next     = sum_reg;
        held_next    = held_reg;
        if (wr_en)
        begin
            sum_next     = sum_new;
            widx_next    = wrap ? '0 : idx_inc[IW-1:0];
            wrapped_next = wrapped_reg || wrap;
        end
        if (cfg.clear)
        begin
            widx_next    = '0;
            wrapped_next = 1'b0;
            sum_next     = '0;
        end
        if (div_done)
        begin
            held_next = isma_pkg::DATA_W'(quotient[SW-1:0]);
        end
        mvalid_next = mvalid_reg && !m_axis_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        if (out_load)
        begin
            mvalid_next = 1'b1;
            mdata_next  = held_reg;
            muser_next  = item_reg.stored;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= isma_pkg::B_IDLE;
            widx_reg    <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
            held_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            widx_reg    <= widx_next;
            wrapped_reg <= wrapped_next;
            sum_reg     <= sum_next;
            held_reg    <= held_next;
            mvalid_reg  <= mvalid_next;
        end
    end

endmodule

@@ sv/interval_sampled_moving_average_core.sv @@
// Top level of the interval-sampled moving average: config registers, front, queue, back.
// Depends on isma_pkg, isma_front, isma_fifo and isma_back.
//
// Every accepted tick gives exactly one result, in order. Ticks enter a four-entry
// request queue at up to one per cycle until it fills. A tick that stores no sample
// goes from the back part's idle state straight to its output state, waiting there
// only for the receiver; a tick that stores a sample takes a ring read, an update
// step and the restoring divider, and the divider's bit-serial run sets the
// sustained rate under steady sampling. A configuration write clears the ring, write
// index and sum through a fill flag, with no clearing pass; the elapsed
// tick count and held average keep their values. Write configuration only while idle.
module interval_sampled_moving_average_core #(
    parameter int WINDOW_MAX  = isma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [isma_pkg::DATA_W-1:0]     s_axis_tdata,   // [15:0] sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [isma_pkg::DATA_W-1:0]     m_axis_tdata,   // [15:0] average
    output logic [0:0]                      m_axis_tuser,   // [0] sampled
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [isma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [isma_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [isma_pkg::INTERVAL_W-1:0] interval_reg, interval_next;
    logic [isma_pkg::WINDOW_W-1:0]   window_reg, window_next;
    logic                            cfg_clear;
    isma_pkg::cfg_ctl_t              cfg;

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    isma_pkg::tick_t q_in;
    isma_pkg::tick_t q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        interval_next = interval_reg;
        window_next   = window_reg;
        cfg_clear     = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                isma_pkg::CFG_INTERVAL:
                begin
                    interval_next = cfg_data[isma_pkg::INTERVAL_W-1:0];
                    cfg_clear     = 1'b1;
                end
                isma_pkg::CFG_WINDOW:
                begin
                    window_next = cfg_data[isma_pkg::WINDOW_W-1:0];
                    cfg_clear   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        cfg.clear    = cfg_clear;
        cfg.interval = interval_reg;
        cfg.window   = window_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= isma_pkg::INTERVAL_RESET;
            window_reg   <= isma_pkg::WINDOW_RESET;
        end
        else
        begin
            interval_reg <= interval_next;
            window_reg   <= window_next;
        end
    end

    isma_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    isma_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    isma_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ sv/isma_check.sv @@
// Port-level checker for interval_sampled_moving_average_core, with its bind.
// Depends on isma_pkg.
module isma_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [isma_pkg::DATA_W-1:0]     s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [isma_pkg::DATA_W-1:0]     m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [isma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [isma_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                        in_acc;
    logic                        out_acc;
    logic [3:0]                  pending_reg;
    logic [isma_pkg::DATA_W-1:0] last_avg_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_avg_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {3'b000, in_acc} - {3'b000, out_acc};
            if (out_acc)
            begin
                last_avg_reg <= m_axis_tdata;
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no result without an outstanding request
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 4'd0)
        else $error("result without pending request");

    // input backpressure only with a full queue of outstanding requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> pending_reg >= 4'(isma_pkg::QUEUE_DEPTH))
        else $error("input stalled with queue not full");

    // non-sampling tick repeats the held average
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !m_axis_tuser[0] |-> m_axis_tdata == last_avg_reg)
        else $error("held average changed without a stored sample");

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

endmodule

bind interval_sampled_moving_average_core isma_check u_isma_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

@@ bench/light_average_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the interval-sampled moving average core: tracks settings
// writes and accepted ticks, predicts each result and compares it in order.
// Depends on isma_pkg.
module light_average_checker
    import isma_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DATA_W-1:0]     m_axis_tdata,
    input  logic [0:0]            m_axis_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int RING_DEPTH = WINDOW_MAX_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic              sampled;
    } light_result_t;

    logic [DATA_W-1:0]     ring [RING_DEPTH];
    int unsigned           ring_pos;
    int unsigned           ring_sum;
    logic [INTERVAL_W-1:0] elapsed;
    logic [DATA_W-1:0]     held;
    logic [INTERVAL_W-1:0] interval_set;
    logic [WINDOW_W-1:0]   window_set;
    light_result_t         pending_averages [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void clear_ring();
        foreach (ring[i])
            ring[i] = '0;
        ring_pos = 0;
        ring_sum = 0;
    endfunction

    function automatic light_result_t advance_tick(input logic [DATA_W-1:0] value);
        light_result_t result;
        int unsigned   span;
        int unsigned   period;
        int unsigned   slot;
        span = (window_set == 0) ? 1 : (window_set > RING_DEPTH) ? RING_DEPTH : window_set;
        period = (interval_set == 0) ? 1 : interval_set;
        result.sampled = 1'b0;
        if (elapsed != '1)
            elapsed = elapsed + 1'b1;
        if (elapsed >= period)
        begin
            slot = (ring_pos >= span) ? 0 : ring_pos;
            ring_sum = ring_sum - ring[slot] + value;
            ring[slot] = value;
            ring_pos = (slot + 1 >= span) ? 0 : slot + 1;
            elapsed = '0;
            held = DATA_W'(ring_sum / span);
            result.sampled = 1'b1;
        end
        result.average = held;
        return result;
    endfunction

    task automatic report(input bit owed, input light_result_t want, input light_result_t seen);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            if (owed)
                $display("%0t: mismatch: expected average %h sampled %b, got average %h sampled %b",
                         $realtime, want.average, want.sampled, seen.average, seen.sampled);
            else
                $display("%0t: unexpected result: average %h sampled %b",
                         $realtime, seen.average, seen.sampled);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        light_result_t seen;
        light_result_t want;
        if (!rst_n)
        begin
            clear_ring();
            elapsed = '0;
            held = '0;
            interval_set = INTERVAL_RESET;
            window_set = WINDOW_RESET;
            pending_averages.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INTERVAL:
                    begin
                        interval_set = cfg_data[INTERVAL_W-1:0];
                        clear_ring();
                    end
                    CFG_WINDOW:
                    begin
                        window_set = cfg_data[WINDOW_W-1:0];
                        clear_ring();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.average = m_axis_tdata;
                seen.sampled = m_axis_tuser[0];
                if (pending_averages.size() == 0)
                    report(1'b0, seen, seen);
                else
                begin
                    want = pending_averages.pop_front();
                    if (seen !== want)
                        report(1'b1, want, seen);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_averages.push_back(advance_tick(s_axis_tdata));
        end
        outstanding = pending_averages.size();
    end

endmodule

@@ bench/tb_interval_sampled_moving_average_core.sv @@
`timescale 1ns / 100ps
// Testbench top for the interval-sampled moving average core: drives ticks and
// settings writes under varied back-pressure and gives the verdict.
// Depends on isma_pkg, light_average_checker and the core itself.
module tb_interval_sampled_moving_average_core;
    import isma_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_TICKS   = 128;
    localparam int LONG_TICKS    = 16;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors_seen;
    int results_owed;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_left  = 0;
    int cycle_count = 0;

    interval_sampled_moving_average_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    light_average_checker light_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (errors_seen),
        .outstanding   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic offer_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] index,
                                 input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] setting;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_INTERVAL;
        cfg_data      = '0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: long interval, nothing stored yet
        offer_sample(16'h1234);
        offer_sample(16'hFFFF);

        // zero interval and zero window act as one
        drain_and_settle();
        write_setting(CFG_INTERVAL, 16'h0000);
        write_setting(CFG_WINDOW, 16'h0000);
        offer_sample(16'hFFFF);
        offer_sample(16'h0000);
        offer_sample(16'h8000);
        offer_sample(16'h0001);

        // window above maximum, high data bits ignored
        drain_and_settle();
        write_setting(CFG_WINDOW, 16'hFFFF);
        write_setting(CFG_INTERVAL, 16'h0001);
        offer_sample(16'hFFFF);
        offer_sample(16'hFFFF);
        offer_sample(16'hAAAA);
        offer_sample(16'h5555);

        // writes to unused indexes must leave the window intact
        drain_and_settle();
        write_setting(CFG_SPARE_LO, 16'h0000);
        write_setting(CFG_SPARE_HI, 16'hFFFF);
        offer_sample(16'h0000);
        offer_sample(16'h7FFF);

        drain_and_settle();
        write_setting(CFG_WINDOW, 16'h0040);
        write_setting(CFG_INTERVAL, 16'h0002);
        offer_sample(16'hFFFF);
        offer_sample(16'hFFFE);
        offer_sample(16'h0000);
        offer_sample(16'h8001);
        offer_sample(16'hFFFF);
        offer_sample(16'h0100);

        drain_and_settle();
        write_setting(CFG_INTERVAL, 16'hFFFF);
        write_setting(CFG_WINDOW, 16'h0003);
        offer_sample(16'h4321);
        offer_sample(16'hFFFF);
        offer_sample(16'h0000);

        // maximum interval: the count runs on, the held average repeats
        for (int n = 0; n < LONG_TICKS; n++)
            offer_sample(DATA_W'($urandom));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_and_settle();
            case (phase % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 76;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 76;
                end
                default:
                begin
                    send_idle  = 6;
                    recv_stall = 6;
                end
            endcase
            if (phase == 0)
            begin
                write_setting(CFG_INTERVAL, 16'h0001);
                write_setting(CFG_WINDOW, 16'h0040);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       setting = '0;
                        1:       setting = CFG_DATA_W'($urandom_range(1, 3));
                        2:       setting = CFG_DATA_W'($urandom_range(4, 16));
                        default: setting = 16'h0001;
                    endcase
                    write_setting(CFG_INTERVAL, setting);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    setting[CFG_DATA_W-1:WINDOW_W] = (CFG_DATA_W - WINDOW_W)'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        setting[WINDOW_W-1:0] = WINDOW_W'($urandom_range(0, 127));
                    else
                        setting[WINDOW_W-1:0] = WINDOW_W'($urandom_range(1, 8));
                    write_setting(CFG_WINDOW, setting);
                end
                if ($urandom_range(0, 4) == 0)
                    write_setting(CFG_SPARE_HI, CFG_DATA_W'($urandom));
            end
            // receiver holds off while ticks keep coming: queue fills, input stalls
            if (phase == 1)
                hold_left = HOLD_CYCLES;
            for (int n = 0; n < PHASE_TICKS; n++)
                offer_sample((phase == 0 && n < 80) ? DATA_W'('1) : pick_sample());
        end

        drain_and_settle();
        if (errors_seen == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
